// ===== rtl/chunked_tile_store_assert.svh =====
// Assertion macros shared by the tile store RTL.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef CHUNKED_TILE_STORE_ASSERT_SVH
`define CHUNKED_TILE_STORE_ASSERT_SVH

`ifndef SYNTHESIS

// The consequence must hold in the same cycle as the condition.
`define CTS_ASSERT_SAME(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (cons)) \
        else $error("chunked_tile_store assertion failed");

// The consequence must hold in the cycle after the condition.
`define CTS_ASSERT_NEXT(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (cons)) \
        else $error("chunked_tile_store assertion failed");

`else

`define CTS_ASSERT_SAME(label, clk, rstn, cond, cons)
`define CTS_ASSERT_NEXT(label, clk, rstn, cond, cons)

`endif

`endif

// ===== rtl/cts_pkg.sv =====
package cts_pkg;

    // Item field widths.
    localparam int COORD_W    = 16;
    localparam int LAYER_W    = 8;
    localparam int VALUE_W    = 16;
    localparam int CFG_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 24;

    // Commands carried in s_tuser.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Register indexes on the configuration port.
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_CHUNKS_ACROSS = 2'd0;
    localparam cfg_index_t CFG_CHUNKS_DOWN   = 2'd1;
    localparam cfg_index_t CFG_LAYERS_IN_USE = 2'd2;

    // Register values after reset.
    localparam logic [CFG_W-1:0] RST_CHUNKS_ACROSS = 3'd4;
    localparam logic [CFG_W-1:0] RST_CHUNKS_DOWN   = 3'd4;
    localparam logic [CFG_W-1:0] RST_LAYERS_IN_USE = 3'd1;

    // Value seen for a tile in an allocated chunk that was never written.
    localparam logic [VALUE_W-1:0] UNWRITTEN_VALUE = 16'd1;

    // Tile values that can be walked over.
    localparam logic [VALUE_W-1:0] PASS_VALUE_LO  = 16'd1;
    localparam logic [VALUE_W-1:0] PASS_VALUE_MID = 16'd3;
    localparam logic [VALUE_W-1:0] PASS_VALUE_HI  = 16'd4;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESOLVE
    } state_t;

endpackage

// ===== rtl/cts_tile_ram.sv =====
module cts_tile_ram #(
    parameter int WIDTH  = 17,
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/chunked_tile_store.sv =====
// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   s_tuser = command, s_tdata = x, y, z, write value
// m_        out  m_tvalid/m_tready   m_tdata = tile value, in-bounds flag, passable flag
// cfg_      in   cfg_we              cfg_index selects the register, cfg_wdata is the value
//
// Each item is accepted in ST_IDLE and resolved in ST_RESOLVE, as the RAM read is
// registered: the accept edge reads the tile word, and the next edge writes it back (on
// an in-bounds write) and loads the result register; s_tready is low while it resolves.
// After reset the block clears every tile word, one per cycle, all 16384 at the defaults
// (MAX_LAYERS * MAX_CHUNKS_PER_AXIS^2 * 4^CHUNK_SHIFT), with s_tready low. A stalled
// result holds in the output register, and a new item is taken in the cycle it leaves.
`include "chunked_tile_store_assert.svh"

module chunked_tile_store #(
    parameter int CHUNK_SHIFT         = 4,
    parameter int MAX_CHUNKS_PER_AXIS = 4,
    parameter int MAX_LAYERS          = 4,
    parameter int TILE_BITS           = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input items.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Bits from the lowest: tile_x[15:0], tile_y[31:16], tile_z[39:32], write_value[55:40].
    input  logic [cts_pkg::S_TDATA_W-1:0]  s_tdata,
    // Bit 0: command (0 read, 1 write).
    input  logic                           s_tuser,
    // Result items.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Bits from the lowest: tile_value[15:0], in_bounds[16], passable[17], zero fill[23:18].
    output logic [cts_pkg::M_TDATA_W-1:0]  m_tdata,
    // Configuration writes.
    input  logic                           cfg_we,
    input  logic [cts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cts_pkg::CFG_W-1:0]      cfg_wdata
);

    import cts_pkg::*;

    // Geometry of the map. Chunks sit at fixed places, so the address of a tile is
    // the chunk number followed by the row and column inside the chunk.
    localparam int CHUNK_COUNT     = MAX_LAYERS * MAX_CHUNKS_PER_AXIS * MAX_CHUNKS_PER_AXIS;
    localparam int CHUNK_W         = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
    localparam int TILES_PER_CHUNK = 1 << (2 * CHUNK_SHIFT);
    localparam int TILE_COUNT      = CHUNK_COUNT * TILES_PER_CHUNK;
    localparam int ADDR_W          = CHUNK_W + 2 * CHUNK_SHIFT;
    // A RAM word holds the tile value and, on top, the bit that marks it written.
    localparam int WORD_W          = TILE_BITS + 1;

    // Configuration registers.
    logic [CFG_W-1:0] chunks_across_reg;
    logic [CFG_W-1:0] chunks_down_reg;
    logic [CFG_W-1:0] layers_in_use_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunks_across_reg <= RST_CHUNKS_ACROSS;
            chunks_down_reg   <= RST_CHUNKS_DOWN;
            layers_in_use_reg <= RST_LAYERS_IN_USE;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CHUNKS_ACROSS: chunks_across_reg <= cfg_wdata;
                CFG_CHUNKS_DOWN:   chunks_down_reg   <= cfg_wdata;
                CFG_LAYERS_IN_USE: layers_in_use_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Field unpacking.
    logic [COORD_W-1:0] in_x;
    logic [COORD_W-1:0] in_y;
    logic [LAYER_W-1:0] in_z;
    logic [VALUE_W-1:0] in_value;

    assign in_x     = s_tdata[15:0];
    assign in_y     = s_tdata[31:16];
    assign in_z     = s_tdata[39:32];
    assign in_value = s_tdata[55:40];

    // Address decode. A set sign bit on any coordinate puts the item out of bounds.
    // Each count is compared both with the register and with the hardware maximum,
    // which is the same as comparing with the saturated count.
    logic [COORD_W-1:0] cx_ext;
    logic [COORD_W-1:0] cy_ext;
    logic [COORD_W-1:0] cz_ext;
    logic               x_ok;
    logic               y_ok;
    logic               z_ok;
    logic               dec_inb;
    logic [31:0]        chunk_full;
    logic [ADDR_W-1:0]  dec_addr;

    assign cx_ext = COORD_W'(in_x[COORD_W-2:CHUNK_SHIFT]);
    assign cy_ext = COORD_W'(in_y[COORD_W-2:CHUNK_SHIFT]);
    assign cz_ext = COORD_W'(in_z[LAYER_W-2:0]);

    assign x_ok = !in_x[COORD_W-1] && (cx_ext < COORD_W'(chunks_across_reg))
                  && (cx_ext < COORD_W'(MAX_CHUNKS_PER_AXIS));
    assign y_ok = !in_y[COORD_W-1] && (cy_ext < COORD_W'(chunks_down_reg))
                  && (cy_ext < COORD_W'(MAX_CHUNKS_PER_AXIS));
    assign z_ok = !in_z[LAYER_W-1] && (cz_ext < COORD_W'(layers_in_use_reg))
                  && (cz_ext < COORD_W'(MAX_LAYERS));
    assign dec_inb = x_ok && y_ok && z_ok;

    assign chunk_full = (32'(cz_ext) * 32'(MAX_CHUNKS_PER_AXIS) + 32'(cy_ext))
                        * 32'(MAX_CHUNKS_PER_AXIS) + 32'(cx_ext);
    assign dec_addr   = {chunk_full[CHUNK_W-1:0], in_y[CHUNK_SHIFT-1:0],
                         in_x[CHUNK_SHIFT-1:0]};

    // Control state and the item held while its RAM word is read.
    state_t               state_reg;
    state_t               state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg;
    logic                 cmd_reg;
    logic                 inb_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [CHUNK_W-1:0]   chunk_reg;
    logic [TILE_BITS-1:0] wval_reg;
    logic [CHUNK_COUNT-1:0] present_reg;
    logic [CHUNK_COUNT-1:0] present_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [VALUE_W-1:0]   out_value_reg;
    logic [VALUE_W-1:0]   out_value_next;
    logic                 out_inb_reg;
    logic                 out_pass_reg;
    logic                 out_pass_next;

    logic                 accept;
    logic                 load_out;
    logic                 ram_rd_en;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WORD_W-1:0]    ram_rdata;

    assign accept = s_tvalid && s_tready;
    // Only an in-bounds item reads the RAM; others never need the stored word.
    assign ram_rd_en = accept && dec_inb;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            present_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            present_reg   <= present_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= s_tuser;
            inb_reg   <= dec_inb;
            addr_reg  <= dec_addr;
            chunk_reg <= chunk_full[CHUNK_W-1:0];
            wval_reg  <= TILE_BITS'(in_value);
        end
        if (load_out) begin
            out_value_reg <= out_value_next;
            out_inb_reg   <= inb_reg;
            out_pass_reg  <= out_pass_next;
        end
    end

    // Next state, handshake, RAM write-back and result.
    // The read at accept and the write in the resolve cycle never overlap for the next
    // item: s_tready is low in the resolve cycle, so the next read sees the new word.
    always_comb begin
        state_next     = state_reg;
        present_next   = present_reg;
        out_valid_next = out_valid_reg;
        s_tready       = 1'b0;
        load_out       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = {1'b1, wval_reg};
        out_value_next = '0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == ADDR_W'(TILE_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = !out_valid_reg || m_tready;
                if (s_tvalid && s_tready) begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
                if (!inb_reg) begin
                    out_value_next = '0;
                end else if (cmd_reg == CMD_WRITE) begin
                    ram_we                  = 1'b1;
                    present_next[chunk_reg] = 1'b1;
                    out_value_next          = VALUE_W'(wval_reg);
                end else if (present_reg[chunk_reg]) begin
                    out_value_next = ram_rdata[TILE_BITS] ?
                                     VALUE_W'(ram_rdata[TILE_BITS-1:0]) : UNWRITTEN_VALUE;
                end else begin
                    out_value_next = '0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        out_pass_next = out_value_next inside {PASS_VALUE_LO, PASS_VALUE_MID, PASS_VALUE_HI};
    end

    cts_tile_ram #(
        .WIDTH  (WORD_W),
        .DEPTH  (TILE_COUNT),
        .ADDR_W (ADDR_W)
    ) u_tile_ram (
        .aclk    (aclk),
        .rd_en   (ram_rd_en),
        .rd_addr (dec_addr),
        .rd_data (ram_rdata),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - 2){1'b0}}, out_pass_reg, out_inb_reg,
                       out_value_reg};

    // No item is taken while the tile words are being cleared.
    `CTS_ASSERT_SAME(a_no_accept_in_clear, aclk, aresetn, state_reg == ST_CLEAR, !s_tready)
    // An accepted item is resolved in the following cycle.
    `CTS_ASSERT_NEXT(a_accept_resolves, aclk, aresetn, accept, state_reg == ST_RESOLVE)
    // Resolving an item always leaves a result waiting.
    `CTS_ASSERT_NEXT(a_resolve_gives_result, aclk, aresetn, state_reg == ST_RESOLVE,
                     m_tvalid)
    // Outside the clearing pass the RAM is written only by an in-bounds write command.
    `CTS_ASSERT_SAME(a_write_back_legal, aclk, aresetn, ram_we && state_reg != ST_CLEAR,
                     state_reg == ST_RESOLVE && cmd_reg == CMD_WRITE && inb_reg)

endmodule

// ===== dv/tb_chunked_tile_store.sv =====
module tb_chunked_tile_store;

    timeunit 1ns;
    timeprecision 1ps;

    import cts_pkg::*;

    // Geometry of the block as instantiated (its parameter defaults).
    localparam int CHUNK_SHIFT         = 4;
    localparam int MAX_CHUNKS_PER_AXIS = 4;
    localparam int MAX_LAYERS          = 4;
    localparam int CHUNK_DIM           = 1 << CHUNK_SHIFT;
    localparam int TILES_PER_CHUNK     = CHUNK_DIM * CHUNK_DIM;
    localparam int CHUNK_COUNT         = MAX_LAYERS * MAX_CHUNKS_PER_AXIS * MAX_CHUNKS_PER_AXIS;
    localparam int TILE_COUNT          = CHUNK_COUNT * TILES_PER_CHUNK;

    // The register port has one index that selects no register.
    localparam cfg_index_t CFG_UNUSED_INDEX = 2'd3;

    // Run control.
    localparam int RESET_CYCLES     = 6;
    localparam int SETTLE_CYCLES    = 4;
    localparam int HOLD_CYCLES      = 300;
    localparam int PRESSURE_ITEMS   = 40;
    localparam int RANDOM_PHASES    = 9;
    localparam int ITEMS_PER_PHASE  = 150;
    localparam int FULL_RATE_ITEMS  = 250;
    localparam int PRINT_CAP        = 60;
    localparam int TIMEOUT_NS       = 2_000_000;

    // One tile access as it travels on the input channel.
    typedef struct packed {
        logic                        command;
        logic signed [COORD_W-1:0]   tile_x;
        logic signed [COORD_W-1:0]   tile_y;
        logic signed [LAYER_W-1:0]   tile_z;
        logic        [VALUE_W-1:0]   write_value;
    } tile_access_t;

    // One result as it travels on the output channel.
    typedef struct packed {
        logic [VALUE_W-1:0] tile_value;
        logic               in_bounds;
        logic               passable;
    } tile_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_wdata;

    chunked_tile_store uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the map and of the register file, used to work out the
    // result of every item that the block accepts.
    logic [CFG_W-1:0]   shadow_across;
    logic [CFG_W-1:0]   shadow_down;
    logic [CFG_W-1:0]   shadow_layers;
    bit                 shadow_chunk_present [CHUNK_COUNT];
    bit                 shadow_tile_written  [TILE_COUNT];
    logic [VALUE_W-1:0] shadow_tile_store    [TILE_COUNT];

    // Results that the block still owes, oldest first.
    tile_result_t pending_tile_results [$];

    int  mismatches    = 0;
    bit  source_gaps   = 1'b0;
    bit  sink_gaps     = 1'b0;
    bit  hold_results  = 1'b0;

    // The clock runs at 250 MHz.
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // A run that hangs, or that leaves a result owed forever, ends here.
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL chunked_tile_store");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    // Works out the result of one access and updates the shadow map the way
    // the block updates its own store.
    function automatic tile_result_t predict_tile_access(input tile_access_t acc);
        tile_result_t res;
        int           lim_x;
        int           lim_y;
        int           lim_z;
        int           cx;
        int           cy;
        int           lz;
        int           chunk;
        int           tile;
        res   = '0;
        lim_x = (shadow_across > MAX_CHUNKS_PER_AXIS) ? MAX_CHUNKS_PER_AXIS : int'(shadow_across);
        lim_y = (shadow_down > MAX_CHUNKS_PER_AXIS) ? MAX_CHUNKS_PER_AXIS : int'(shadow_down);
        lim_z = (shadow_layers > MAX_LAYERS) ? MAX_LAYERS : int'(shadow_layers);
        // A negative coordinate on any axis is always out of bounds.
        if (!acc.tile_x[COORD_W-1] && !acc.tile_y[COORD_W-1] && !acc.tile_z[LAYER_W-1]) begin
            cx = int'(acc.tile_x[COORD_W-1:CHUNK_SHIFT]);
            cy = int'(acc.tile_y[COORD_W-1:CHUNK_SHIFT]);
            lz = int'(acc.tile_z[LAYER_W-1:0]);
            if (cx < lim_x && cy < lim_y && lz < lim_z) begin
                chunk = (lz * MAX_CHUNKS_PER_AXIS + cy) * MAX_CHUNKS_PER_AXIS + cx;
                tile  = chunk * TILES_PER_CHUNK
                      + int'({acc.tile_y[CHUNK_SHIFT-1:0], acc.tile_x[CHUNK_SHIFT-1:0]});
                res.in_bounds = 1'b1;
                if (acc.command == CMD_WRITE) begin
                    // No tile of a chunk is ever marked written before the chunk is
                    // allocated, so allocation needs no clearing here.
                    shadow_chunk_present[chunk] = 1'b1;
                    shadow_tile_store[tile]     = acc.write_value;
                    shadow_tile_written[tile]   = 1'b1;
                    res.tile_value              = acc.write_value;
                end else if (shadow_chunk_present[chunk]) begin
                    res.tile_value = shadow_tile_written[tile] ? shadow_tile_store[tile]
                                                               : UNWRITTEN_VALUE;
                end
            end
        end
        res.passable = (res.tile_value == PASS_VALUE_LO) || (res.tile_value == PASS_VALUE_MID)
                    || (res.tile_value == PASS_VALUE_HI);
        return res;
    endfunction

    // Offers one item and returns in the time step of the edge that accepts it.
    // With source gaps on, a random burst of idle cycles may come first.
    task automatic send_access(input tile_access_t acc);
        if (source_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= acc.command;
        s_tdata  <= {acc.write_value, acc.tile_z, acc.tile_y, acc.tile_x};
        do @(posedge aclk); while (!s_tready);
        pending_tile_results.push_back(predict_tile_access(acc));
    endtask

    task automatic send_fields(input logic cmd, input int x, input int y, input int z,
                               input int wv);
        tile_access_t acc;
        acc.command     = cmd;
        acc.tile_x      = COORD_W'(x);
        acc.tile_y      = COORD_W'(y);
        acc.tile_z      = LAYER_W'(z);
        acc.write_value = VALUE_W'(wv);
        send_access(acc);
    endtask

    // Most accesses land on a few tiles near the low corner of a few chunks, so
    // that reads often find tiles that were written earlier. The rest spread
    // over the edges of the configured area or over the whole coordinate space.
    function automatic tile_access_t random_access();
        tile_access_t acc;
        int           pick;
        pick        = $urandom_range(0, 99);
        acc.command = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
        if (pick < 60) begin
            acc.tile_x = COORD_W'($urandom_range(0, 4) * CHUNK_DIM + $urandom_range(0, 3));
            acc.tile_y = COORD_W'($urandom_range(0, 4) * CHUNK_DIM + $urandom_range(0, 3));
            acc.tile_z = LAYER_W'($urandom_range(0, 4));
        end else if (pick < 85) begin
            acc.tile_x = COORD_W'($urandom_range(0, 79));
            acc.tile_y = COORD_W'($urandom_range(0, 79));
            acc.tile_z = LAYER_W'($urandom_range(0, 5));
        end else begin
            acc.tile_x = COORD_W'($urandom);
            acc.tile_y = COORD_W'($urandom);
            acc.tile_z = LAYER_W'($urandom);
        end
        acc.write_value = ($urandom_range(0, 9) < 4) ? VALUE_W'($urandom_range(0, 5))
                                                     : VALUE_W'($urandom);
        return acc;
    endfunction

    // Stops offering items and waits until every owed result has arrived,
    // then lets the block's pipeline settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_tile_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes one register. The enable is held for one edge and then dropped a
    // step later, so back-to-back writes never assign it twice in one step.
    task automatic write_register(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_CHUNKS_ACROSS: shadow_across = val;
            CFG_CHUNKS_DOWN:   shadow_down   = val;
            CFG_LAYERS_IN_USE: shadow_layers = val;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Changes the area in use while the block is idle. A write to the unused
    // index goes along every time; it must change nothing.
    task automatic set_layout(input int across, input int down, input int layers);
        wait_drained();
        write_register(CFG_CHUNKS_ACROSS, CFG_W'(across));
        write_register(CFG_CHUNKS_DOWN, CFG_W'(down));
        write_register(CFG_LAYERS_IN_USE, CFG_W'(layers));
        write_register(CFG_UNUSED_INDEX, CFG_W'($urandom_range(0, 7)));
    endtask

    // Hands out ready. It idles in random bursts while sink gaps are on, and
    // holds off for a long counted stretch when a test asks for it.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_results) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_results = 1'b0;
                m_tready <= 1'b1;
            end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compares every result that leaves the block with the oldest owed one.
    always @(posedge aclk) begin
        tile_result_t got;
        tile_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.tile_value = m_tdata[VALUE_W-1:0];
            got.in_bounds  = m_tdata[VALUE_W];
            got.passable   = m_tdata[VALUE_W+1];
            if (pending_tile_results.size() == 0) begin
                report_mismatch($sformatf("result value %0h arrived with nothing owed",
                                          got.tile_value));
            end else begin
                want = pending_tile_results.pop_front();
                if (got.tile_value !== want.tile_value)
                    report_mismatch($sformatf("tile_value %0h, expected %0h",
                                              got.tile_value, want.tile_value));
                if (got.in_bounds !== want.in_bounds)
                    report_mismatch($sformatf("in_bounds %0b, expected %0b",
                                              got.in_bounds, want.in_bounds));
                if (got.passable !== want.passable)
                    report_mismatch($sformatf("passable %0b, expected %0b",
                                              got.passable, want.passable));
            end
        end
    end

    // Directed accesses under the reset layout of 4 by 4 chunks and one layer:
    // never-written chunks, unwritten tiles of allocated chunks, the value
    // extremes, passable and non-passable values, every out-of-bounds cause
    // on a read or a write, and the coordinate extremes.
    task automatic test_directed_access();
        send_fields(CMD_READ,  0, 0, 0, 0);            // chunk never written reads 0
        send_fields(CMD_WRITE, 5, 2, 0, 3);            // allocates chunk 0
        send_fields(CMD_READ,  5, 2, 0, 0);
        send_fields(CMD_READ,  6, 2, 0, 0);            // unwritten tile reads 1
        send_fields(CMD_WRITE, 63, 63, 0, 16'hFFFF);   // far corner, largest value
        send_fields(CMD_READ,  63, 63, 0, 0);
        send_fields(CMD_WRITE, 16, 0, 0, 0);           // smallest value
        send_fields(CMD_READ,  17, 0, 0, 0);
        send_fields(CMD_WRITE, 0, 0, 0, 4);
        send_fields(CMD_READ,  0, 0, 0, 0);
        send_fields(CMD_WRITE, 1, 0, 0, 2);            // not a passable value
        send_fields(CMD_READ,  1, 0, 0, 0);
        send_fields(CMD_WRITE, 64, 0, 0, 7);           // one chunk past x: ignored
        send_fields(CMD_READ,  64, 0, 0, 0);
        send_fields(CMD_WRITE, 0, 64, 0, 7);           // one chunk past y: ignored
        send_fields(CMD_WRITE, 0, 0, 1, 9);            // layer not in use: ignored
        send_fields(CMD_READ,  0, 0, 1, 0);
        send_fields(CMD_READ,  -1, 0, 0, 0);           // negative coordinates
        send_fields(CMD_WRITE, -16, 5, 0, 3);
        send_fields(CMD_READ,  0, -1, 0, 0);
        send_fields(CMD_WRITE, 0, 0, -1, 3);
        send_fields(CMD_READ,  32767, 32767, 127, 0);
        send_fields(CMD_READ,  -32768, -32768, -128, 0);
    endtask

    // Register extremes: a zero count shuts the axis off, counts above the
    // maximum saturate, and the unused index changes nothing.
    task automatic test_register_limits();
        set_layout(0, 4, 1);
        send_fields(CMD_READ,  5, 2, 0, 0);
        send_fields(CMD_WRITE, 5, 2, 0, 1);
        set_layout(7, 7, 7);
        send_fields(CMD_WRITE, 63, 63, 3, 5);
        send_fields(CMD_READ,  63, 63, 3, 0);
        send_fields(CMD_READ,  64, 64, 3, 0);
        send_fields(CMD_READ,  0, 0, 4, 0);
    endtask

    // Random accesses in phases, each under its own layout, with idle bursts
    // on both channels. The first phases cover the register extremes.
    task automatic test_random_layouts();
        int across;
        int down;
        int layers;
        source_gaps = 1'b1;
        sink_gaps   = 1'b1;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin across = 4; down = 4; layers = 4; end
                1: begin across = 7; down = 7; layers = 7; end
                2: begin across = 0; down = 4; layers = 4; end
                3: begin across = 4; down = 0; layers = 4; end
                4: begin across = 4; down = 4; layers = 0; end
                5: begin across = 1; down = 1; layers = 1; end
                6: begin across = 3; down = 2; layers = 4; end
                default: begin
                    across = $urandom_range(0, 7);
                    down   = $urandom_range(0, 7);
                    layers = $urandom_range(0, 7);
                end
            endcase
            set_layout(across, down, layers);
            repeat (ITEMS_PER_PHASE) send_access(random_access());
        end
    endtask

    // The receiver holds off for a long stretch while items keep coming, so
    // the output register fills and the block has to drop s_tready.
    task automatic test_result_backpressure();
        set_layout(4, 4, 4);
        source_gaps  = 1'b0;
        hold_results = 1'b1;
        repeat (PRESSURE_ITEMS) send_access(random_access());
    endtask

    // Back-to-back items with ready always high: the block at full rate.
    task automatic test_full_rate();
        set_layout($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4));
        source_gaps = 1'b0;
        sink_gaps   = 1'b0;
        repeat (FULL_RATE_ITEMS) send_access(random_access());
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_READ;
        cfg_we    = 1'b0;
        cfg_index = CFG_CHUNKS_ACROSS;
        cfg_wdata = '0;
        shadow_across = RST_CHUNKS_ACROSS;
        shadow_down   = RST_CHUNKS_DOWN;
        shadow_layers = RST_LAYERS_IN_USE;
        foreach (shadow_chunk_present[i]) shadow_chunk_present[i] = 1'b0;
        foreach (shadow_tile_written[i]) shadow_tile_written[i] = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // The block clears its store after reset with s_tready low; the first
        // item simply waits for that pass to end.
        test_directed_access();
        test_register_limits();
        test_random_layouts();
        test_result_backpressure();
        test_full_rate();

        wait_drained();
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS chunked_tile_store");
        end else begin
            $display("FAIL chunked_tile_store");
        end
        $finish;
    end

endmodule
